/* sv/pbba_pkg.sv */
package pbba_pkg;

	localparam int FIELD_W  = 32;
	localparam int BONE_W   = 8;
	localparam int WEIGHT_W = 16;
	localparam int CNT_W    = 9;
	localparam int NUM_INFL = 4;
	localparam int INFL_W   = 2;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam int REG_W    = PADDR_W - 2;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [REG_W-1:0] REG_BONE_COUNT = '0;

	typedef struct packed {
		logic take_item;
		logic clear_start;
		logic sweep_step;
		logic lookup;
		logic merge;
		logic load_result;
	} cmd_t;

	typedef struct packed {
		logic [1:0] in_opcode;
		logic [1:0] opcode;
		logic       sweep_done;
		logic       infl_last;
	} sts_t;

endpackage

/* sv/pbba_in_if.sv */
interface pbba_in_if
	import pbba_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 opcode;
	logic signed [FIELD_W-1:0]  pos_x;
	logic signed [FIELD_W-1:0]  pos_y;
	logic signed [FIELD_W-1:0]  pos_z;
	logic [BONE_W-1:0]          bone_a;
	logic [BONE_W-1:0]          bone_b;
	logic [BONE_W-1:0]          bone_c;
	logic [BONE_W-1:0]          bone_d;
	logic signed [WEIGHT_W-1:0] weight_a;
	logic signed [WEIGHT_W-1:0] weight_b;
	logic signed [WEIGHT_W-1:0] weight_c;
	logic signed [WEIGHT_W-1:0] weight_d;

	modport source (
		output valid, opcode, pos_x, pos_y, pos_z, bone_a, bone_b, bone_c, bone_d,
			weight_a, weight_b, weight_c, weight_d,
		input ready
	);
	modport sink (
		input valid, opcode, pos_x, pos_y, pos_z, bone_a, bone_b, bone_c, bone_d,
			weight_a, weight_b, weight_c, weight_d,
		output ready
	);
endinterface

/* sv/pbba_out_if.sv */
interface pbba_out_if
	import pbba_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] low_x;
	logic signed [FIELD_W-1:0] low_y;
	logic signed [FIELD_W-1:0] low_z;
	logic signed [FIELD_W-1:0] high_x;
	logic signed [FIELD_W-1:0] high_y;
	logic signed [FIELD_W-1:0] high_z;
	logic                      box_present;

	modport source (
		output valid, low_x, low_y, low_z, high_x, high_y, high_z, box_present,
		input ready
	);
	modport sink (
		input valid, low_x, low_y, low_z, high_x, high_y, high_z, box_present,
		output ready
	);
endinterface

/* sv/pbba_ctrl.sv */
module pbba_ctrl
	import pbba_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_SWEEP  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_LOOKUP = 5'b00100,
		ST_MERGE  = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					cmd.take_item = 1'b1;
					unique case (sts.in_opcode)
						OP_CLEAR: begin
							cmd.clear_start = 1'b1;
							state_d         = ST_SWEEP;
						end
						OP_ADD, OP_READ: begin
							state_d = ST_LOOKUP;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = (sts.opcode == OP_READ) ? ST_RESULT : ST_MERGE;
			end
			ST_MERGE: begin
				cmd.merge = 1'b1;
				state_d   = sts.infl_last ? ST_IDLE : ST_LOOKUP;
			end
			ST_RESULT: begin
				if (out_free) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/pbba_dp.sv */
module pbba_dp
	import pbba_pkg::*;
#(
	parameter int MAX_BONES   = 256,
	parameter int COORD_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	output sts_t                       sts,
	input  logic [CNT_W-1:0]           bone_count,
	input  logic [1:0]                 opcode,
	input  logic signed [FIELD_W-1:0]  pos_x,
	input  logic signed [FIELD_W-1:0]  pos_y,
	input  logic signed [FIELD_W-1:0]  pos_z,
	input  logic [BONE_W-1:0]          bone_a,
	input  logic [BONE_W-1:0]          bone_b,
	input  logic [BONE_W-1:0]          bone_c,
	input  logic [BONE_W-1:0]          bone_d,
	input  logic signed [WEIGHT_W-1:0] weight_a,
	input  logic signed [WEIGHT_W-1:0] weight_b,
	input  logic signed [WEIGHT_W-1:0] weight_c,
	input  logic signed [WEIGHT_W-1:0] weight_d,
	output logic signed [FIELD_W-1:0]  low_x,
	output logic signed [FIELD_W-1:0]  low_y,
	output logic signed [FIELD_W-1:0]  low_z,
	output logic signed [FIELD_W-1:0]  high_x,
	output logic signed [FIELD_W-1:0]  high_y,
	output logic signed [FIELD_W-1:0]  high_z,
	output logic                       box_present
);

	localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
	localparam int CW = COORD_WIDTH;
	localparam int WW = (CW > FIELD_W) ? CW : FIELD_W;
	localparam logic signed [WW-1:0] C_HI = WW'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam logic signed [WW-1:0] C_LO = WW'(-((64'sd1 <<< (CW - 1)) - 64'sd1) - 64'sd1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BONES - 1);

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		logic         vld;
		coord_t [2:0] lo;
		coord_t [2:0] hi;
	} entry_t;

	entry_t mem [MAX_BONES];

	logic [1:0]             op_q;
	coord_t [2:0]           pos_q;
	logic [NUM_INFL-1:0][BONE_W-1:0] bone_q;
	logic [NUM_INFL-1:0]    active_q;
	logic                   read_ok_q;
	logic [INFL_W-1:0]      k_q;
	logic [AW-1:0]          sweep_q;
	entry_t                 rd_q;

	logic [NUM_INFL-1:0][BONE_W-1:0]   bone_in;
	logic [NUM_INFL-1:0][WEIGHT_W-1:0] weight_in;
	logic [NUM_INFL-1:0]               in_range;
	logic [2:0][FIELD_W-1:0]           pos_in;
	coord_t [2:0]                      pos_sat;
	entry_t                            merged;
	entry_t                            wr_data;
	logic [AW-1:0]                     wr_addr;
	logic                              wr_en;
	logic                              hit;

	assign bone_in   = {bone_d, bone_c, bone_b, bone_a};
	assign weight_in = {weight_d, weight_c, weight_b, weight_a};
	assign pos_in    = {pos_z, pos_y, pos_x};

	always_comb begin
		logic signed [WW-1:0] wide;
		for (int a = 0; a < 3; a++) begin
			wide = WW'($signed(pos_in[a]));
			if (wide > C_HI) begin
				pos_sat[a] = CW'(C_HI);
			end else if (wide < C_LO) begin
				pos_sat[a] = CW'(C_LO);
			end else begin
				pos_sat[a] = CW'(wide);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_INFL; i++) begin
			in_range[i] = ({1'b0, bone_in[i]} < bone_count) &&
				(32'(bone_in[i]) < 32'(MAX_BONES));
		end
	end

	always_comb begin
		merged     = rd_q;
		merged.vld = 1'b1;
		for (int a = 0; a < 3; a++) begin
			if (!rd_q.vld) begin
				merged.lo[a] = pos_q[a];
				merged.hi[a] = pos_q[a];
			end else begin
				if ($signed(pos_q[a]) < $signed(rd_q.lo[a])) begin
					merged.lo[a] = pos_q[a];
				end
				if ($signed(pos_q[a]) > $signed(rd_q.hi[a])) begin
					merged.hi[a] = pos_q[a];
				end
			end
		end
	end

	always_comb begin
		if (cmd.sweep_step) begin
			wr_en   = 1'b1;
			wr_addr = sweep_q;
			wr_data = '0;
		end else begin
			wr_en   = cmd.merge && active_q[k_q];
			wr_addr = AW'(bone_q[k_q]);
			wr_data = merged;
		end
	end

	assign sts.in_opcode  = opcode;
	assign sts.opcode     = op_q;
	assign sts.sweep_done = (sweep_q == LAST_ADDR);
	assign sts.infl_last  = (k_q == INFL_W'(NUM_INFL - 1));

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			pos_q     <= pos_sat;
			bone_q    <= bone_in;
			read_ok_q <= in_range[0];
			for (int i = 0; i < NUM_INFL; i++) begin
				active_q[i] <= in_range[i] && ($signed(weight_in[i]) > 0);
			end
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.lookup) begin
			rd_q <= mem[AW'(bone_q[k_q])];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_CLEAR;
			k_q     <= '0;
			sweep_q <= '0;
		end else begin
			if (cmd.take_item) begin
				op_q <= opcode;
				k_q  <= '0;
			end else if (cmd.merge) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.clear_start) begin
				sweep_q <= '0;
			end else if (cmd.sweep_step && !sts.sweep_done) begin
				sweep_q <= sweep_q + 1'b1;
			end
		end
	end

	assign hit = read_ok_q && rd_q.vld;

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			box_present <= hit;
			low_x  <= hit ? FIELD_W'($signed(rd_q.lo[0])) : '0;
			low_y  <= hit ? FIELD_W'($signed(rd_q.lo[1])) : '0;
			low_z  <= hit ? FIELD_W'($signed(rd_q.lo[2])) : '0;
			high_x <= hit ? FIELD_W'($signed(rd_q.hi[0])) : '0;
			high_y <= hit ? FIELD_W'($signed(rd_q.hi[1])) : '0;
			high_z <= hit ? FIELD_W'($signed(rd_q.hi[2])) : '0;
		end
	end

endmodule

/* sv/per_bone_bounding_box_accumulator.sv */
// Keeps an axis-aligned box per bone in one table memory with a valid mark per entry. An add
// item is accepted, then each of its four influences reads its bone's entry in the lookup state
// and writes the grown entry back in the merge state, as the table has a single read port and a
// single write port. A read item is accepted and reads its bone's entry; the result is then moved
// into the output register once that register is free, and may wait there while the next item is
// accepted. A clear item sweeps the table one entry a cycle. After reset the same sweep runs
// before the first item is accepted; register writes are taken at any time. Register 0 at byte
// address 0 holds the bone count.
module per_bone_bounding_box_accumulator
	import pbba_pkg::*;
#(
	parameter int MAX_BONES   = 256,
	parameter int COORD_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	pbba_in_if.sink            req,
	pbba_out_if.source         rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [CNT_W-1:0] bone_count_q;
	logic [REG_W-1:0] reg_index;
	cmd_t             cmd;
	sts_t             sts;

	assign pready    = 1'b1;
	assign reg_index = paddr[PADDR_W-1:2];
	assign prdata    = (reg_index == REG_BONE_COUNT) ? PDATA_W'(bone_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bone_count_q <= '0;
		end else if (psel && penable && pwrite && pready && (reg_index == REG_BONE_COUNT)) begin
			bone_count_q <= pwdata[CNT_W-1:0];
		end
	end

	pbba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pbba_dp #(
		.MAX_BONES   (MAX_BONES),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.bone_count  (bone_count_q),
		.opcode      (req.opcode),
		.pos_x       (req.pos_x),
		.pos_y       (req.pos_y),
		.pos_z       (req.pos_z),
		.bone_a      (req.bone_a),
		.bone_b      (req.bone_b),
		.bone_c      (req.bone_c),
		.bone_d      (req.bone_d),
		.weight_a    (req.weight_a),
		.weight_b    (req.weight_b),
		.weight_c    (req.weight_c),
		.weight_d    (req.weight_d),
		.low_x       (rsp.low_x),
		.low_y       (rsp.low_y),
		.low_z       (rsp.low_z),
		.high_x      (rsp.high_x),
		.high_y      (rsp.high_y),
		.high_z      (rsp.high_z),
		.box_present (rsp.box_present)
	);

endmodule
